// File: hw/rtl/psfb_pkg.sv
`timescale 1ns / 1ps
package psfb_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 40;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SYN_LIMIT     = 3'd0,
		REG_UDP_LIMIT     = 3'd1,
		REG_ICMP_LIMIT    = 3'd2,
		REG_WINDOW_LENGTH = 3'd3,
		REG_BLOCK_LENGTH  = 3'd4
	} psfb_reg_t;

	localparam logic [31:0] SYN_LIMIT_RST     = 32'd200;
	localparam logic [31:0] UDP_LIMIT_RST     = 32'd500;
	localparam logic [31:0] ICMP_LIMIT_RST    = 32'd100;
	localparam logic [39:0] WINDOW_LENGTH_RST = 40'd1000000000;
	localparam logic [39:0] BLOCK_LENGTH_RST  = 40'd60000000000;

	localparam logic [15:0] ETH_IPV4             = 16'h0800;
	localparam logic [7:0]  PROTO_TCP            = 8'd6;
	localparam logic [7:0]  PROTO_UDP            = 8'd17;
	localparam logic [7:0]  PROTO_ICMP           = 8'd1;
	localparam logic [15:0] AMP_LEN_LIMIT        = 16'd512;
	localparam logic [15:0] DNS_SOURCE_PORT      = 16'd53;
	localparam logic [15:0] NTP_SOURCE_PORT      = 16'd123;
	localparam logic [15:0] MEMCACHE_SOURCE_PORT = 16'd11211;
	localparam logic [15:0] SSDP_SOURCE_PORT     = 16'd1900;
	localparam logic [15:0] CHARGEN_SOURCE_PORT  = 16'd19;

	localparam logic [2:0] REASON_UNPARSED = 3'd0;
	localparam logic [2:0] REASON_PASS     = 3'd1;
	localparam logic [2:0] REASON_AMP      = 3'd2;
	localparam logic [2:0] REASON_STILL    = 3'd3;
	localparam logic [2:0] REASON_NEW      = 3'd4;

	typedef struct packed {
		logic [31:0] syn_limit;
		logic [31:0] udp_limit;
		logic [31:0] icmp_limit;
		logic [39:0] window_length_ns;
		logic [39:0] block_length_ns;
	} psfb_cfg_t;

	typedef struct packed {
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [31:0] src_address;
		logic        tcp_syn;
		logic        tcp_ack;
		logic [15:0] udp_source_port;
		logic [15:0] udp_length;
		logic        headers_complete;
		logic [63:0] timestamp_ns;
	} psfb_in_t;

	typedef struct packed {
		logic        drop;
		logic [2:0]  verdict_reason;
		logic [31:0] window_total;
		logic [31:0] window_syn;
		logic [31:0] window_udp;
		logic [31:0] window_icmp;
		logic [31:0] window_dropped;
	} psfb_out_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] tag;
		logic [31:0] syn_hits;
		logic [31:0] udp_hits;
		logic [31:0] icmp_hits;
		logic [63:0] window_begin;
		logic        blocked_flag;
		logic [63:0] blocked_until;
	} psfb_entry_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
		logic [31:0] r;
		r = v;
		if (en && v != 32'hFFFF_FFFF) begin
			r = v + 32'd1;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/psfb_ram.sv
`timescale 1ns / 1ps
module psfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/psfb_cfg.sv
`timescale 1ns / 1ps
module psfb_cfg
	import psfb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   we,
	input  logic [CFG_INDEX_W-1:0] index,
	input  logic [CFG_DATA_W-1:0]  data,
	output psfb_cfg_t              cfg
);

	psfb_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.syn_limit        <= SYN_LIMIT_RST;
			cfg_q.udp_limit        <= UDP_LIMIT_RST;
			cfg_q.icmp_limit       <= ICMP_LIMIT_RST;
			cfg_q.window_length_ns <= WINDOW_LENGTH_RST;
			cfg_q.block_length_ns  <= BLOCK_LENGTH_RST;
		end else if (we) begin
			case (psfb_reg_t'(index))
				REG_SYN_LIMIT:     cfg_q.syn_limit        <= data[31:0];
				REG_UDP_LIMIT:     cfg_q.udp_limit        <= data[31:0];
				REG_ICMP_LIMIT:    cfg_q.icmp_limit       <= data[31:0];
				REG_WINDOW_LENGTH: cfg_q.window_length_ns <= data;
				REG_BLOCK_LENGTH:  cfg_q.block_length_ns  <= data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/per_source_flood_blocker_unit.sv
`timescale 1ns / 1ps
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------
// in       | in_valid  | in_stall  | in_data  (psfb_in_t)
// out      | out_valid | out_stall | out_data (psfb_out_t)
// cfg      | cfg_we    | -         | cfg_index, cfg_data
//
// one item at a time, in_stall high until the final step ends: table read on the
// accepting edge, evaluate, then write back the entry and load the output register
// after reset a clearing pass zeroes all TABLE_DEPTH table entries, in_stall high
// a stalled output holds the item in the final step until the result register frees
module per_source_flood_blocker_unit
	import psfb_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  psfb_in_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output psfb_out_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDXW = $clog2(TABLE_DEPTH);
	localparam int ENTW = $bits(psfb_entry_t);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [IDXW-1:0]   clr_ctr_q;
	logic              out_valid_q;
	psfb_out_t         out_data_q;
	logic [63:0]       g_wb_q;
	logic [31:0]       g_total_q;
	logic [31:0]       g_syn_q;
	logic [31:0]       g_udp_q;
	logic [31:0]       g_icmp_q;
	logic [31:0]       g_drop_q;

	psfb_in_t          in_q;
	logic              hit_s2;
	logic              still_s2;
	logic              clear_s2;
	logic              gclear_s2;
	logic [63:0]       until_s2;

	psfb_cfg_t         cfg;
	psfb_entry_t       ent;
	psfb_entry_t       wentry;
	logic [ENTW-1:0]   rdata;
	logic              ram_we;
	logic [IDXW-1:0]   ram_waddr;
	logic [ENTW-1:0]   ram_wdata;
	logic              accept;

	logic              parsed;
	logic              is_syn;
	logic              is_udp;
	logic              is_icmp;
	logic              amp;
	logic [63:0]       now;
	logic              hit;
	logic              wexp;
	logic              gexp;
	logic [64:0]       until_sum;
	logic [63:0]       block_end;

	logic              can_out;
	logic              fin_fire;
	logic [31:0]       new_syn;
	logic [31:0]       new_udp;
	logic [31:0]       new_icmp;
	logic              newly;
	logic [2:0]        reason;
	logic              drop;
	logic              src_write;
	logic [31:0]       n_total;
	logic [31:0]       n_syn;
	logic [31:0]       n_udp;
	logic [31:0]       n_icmp;
	logic [31:0]       n_drop;
	psfb_out_t         res;

	psfb_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	psfb_ram #(
		.WIDTH (ENTW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (in_data.src_address[IDXW-1:0]),
		.rdata (rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign ent      = psfb_entry_t'(rdata);

	// packet classification
	assign now     = in_q.timestamp_ns;
	assign parsed  = in_q.headers_complete && (in_q.ether_type == ETH_IPV4);
	assign is_syn  = (in_q.ip_protocol == PROTO_TCP) && in_q.tcp_syn && !in_q.tcp_ack;
	assign is_udp  = (in_q.ip_protocol == PROTO_UDP);
	assign is_icmp = (in_q.ip_protocol == PROTO_ICMP);
	assign amp     = is_udp && (in_q.udp_length > AMP_LEN_LIMIT) &&
		((in_q.udp_source_port == DNS_SOURCE_PORT) ||
		(in_q.udp_source_port == NTP_SOURCE_PORT) ||
		(in_q.udp_source_port == MEMCACHE_SOURCE_PORT) ||
		(in_q.udp_source_port == SSDP_SOURCE_PORT) ||
		(in_q.udp_source_port == CHARGEN_SOURCE_PORT));

	// evaluate step
	assign hit       = ent.valid && (ent.tag == in_q.src_address);
	assign wexp      = (now - ent.window_begin) > {24'd0, cfg.window_length_ns};
	assign gexp      = (now - g_wb_q) > {24'd0, cfg.window_length_ns};
	assign until_sum = {1'b0, now} + {25'd0, cfg.block_length_ns};
	assign block_end = until_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : until_sum[63:0];

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_data;
		end
		if (state_q == ST_EVAL) begin
			hit_s2    <= hit;
			still_s2  <= hit && ent.blocked_flag && (now < ent.blocked_until);
			clear_s2  <= !hit || ent.blocked_flag || wexp;
			gclear_s2 <= gexp;
			until_s2  <= block_end;
		end
	end

	// final step
	assign can_out  = !out_valid_q || !out_stall;
	assign fin_fire = (state_q == ST_FIN) && can_out;

	assign new_syn  = sat_inc(clear_s2 ? 32'd0 : ent.syn_hits, is_syn);
	assign new_udp  = sat_inc(clear_s2 ? 32'd0 : ent.udp_hits, is_udp);
	assign new_icmp = sat_inc(clear_s2 ? 32'd0 : ent.icmp_hits, is_icmp);
	assign newly    = hit_s2 && !still_s2 &&
		((new_syn > cfg.syn_limit) || (new_udp > cfg.udp_limit) ||
		(new_icmp > cfg.icmp_limit));

	always_comb begin
		if (!parsed) begin
			reason = REASON_UNPARSED;
		end else if (amp) begin
			reason = REASON_AMP;
		end else if (still_s2) begin
			reason = REASON_STILL;
		end else if (newly) begin
			reason = REASON_NEW;
		end else begin
			reason = REASON_PASS;
		end
	end

	assign drop      = parsed && (reason != REASON_PASS);
	assign src_write = fin_fire && parsed && !amp && !still_s2;

	always_comb begin
		wentry.valid         = 1'b1;
		wentry.tag           = in_q.src_address;
		wentry.syn_hits      = new_syn;
		wentry.udp_hits      = new_udp;
		wentry.icmp_hits     = new_icmp;
		wentry.window_begin  = clear_s2 ? now : ent.window_begin;
		wentry.blocked_flag  = newly;
		wentry.blocked_until = newly ? until_s2 : ent.blocked_until;
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_ctr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = src_write;
			ram_waddr = in_q.src_address[IDXW-1:0];
			ram_wdata = wentry;
		end
	end

	// global window counts
	assign n_total = sat_inc(gclear_s2 ? 32'd0 : g_total_q, 1'b1);
	assign n_syn   = sat_inc(gclear_s2 ? 32'd0 : g_syn_q, is_syn);
	assign n_udp   = sat_inc(gclear_s2 ? 32'd0 : g_udp_q, is_udp);
	assign n_icmp  = sat_inc(gclear_s2 ? 32'd0 : g_icmp_q, is_icmp);
	assign n_drop  = sat_inc(gclear_s2 ? 32'd0 : g_drop_q, drop);

	always_comb begin
		res.drop           = drop;
		res.verdict_reason = reason;
		if (parsed) begin
			res.window_total   = n_total;
			res.window_syn     = n_syn;
			res.window_udp     = n_udp;
			res.window_icmp    = n_icmp;
			res.window_dropped = n_drop;
		end else begin
			res.window_total   = g_total_q;
			res.window_syn     = g_syn_q;
			res.window_udp     = g_udp_q;
			res.window_icmp    = g_icmp_q;
			res.window_dropped = g_drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_ctr_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			g_wb_q      <= '0;
			g_total_q   <= '0;
			g_syn_q     <= '0;
			g_udp_q     <= '0;
			g_icmp_q    <= '0;
			g_drop_q    <= '0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_ctr_q <= clr_ctr_q + 1'b1;
					if (clr_ctr_q == IDXW'(TABLE_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (can_out) begin
						state_q     <= ST_IDLE;
						out_data_q  <= res;
						if (parsed) begin
							g_wb_q    <= gclear_s2 ? now : g_wb_q;
							g_total_q <= n_total;
							g_syn_q   <= n_syn;
							g_udp_q   <= n_udp;
							g_icmp_q  <= n_icmp;
							g_drop_q  <= n_drop;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
